// File: design/fat_bad_cluster_scanner_assert.svh
// ----------------------------------------------------------------------------
// FAT bad cluster scanner assertion macros
// Shorthand for the concurrent checks at the end of the scanner module.
// ----------------------------------------------------------------------------
`ifndef FAT_BAD_CLUSTER_SCANNER_ASSERT_SVH
`define FAT_BAD_CLUSTER_SCANNER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define FBCS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");

// A condition that holds in the same cycle as its trigger.
`define FBCS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// A condition that holds in the cycle after its trigger.
`define FBCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: design/fbcs_pkg.sv
// ----------------------------------------------------------------------------
// FAT bad cluster scanner package
// Shared types, classification limits and helpers for the table scanner.
// ----------------------------------------------------------------------------
package fbcs_pkg;

  localparam int unsigned CNT_W  = 28;
  localparam int unsigned SECT_W = 32;

  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [SECT_W-1:0] sector_t;

  // Saturation point of the 28-bit counters and of the entry number.
  localparam count_t SAT28 = 28'hfffffff;

  // Classification limits for the three table formats.
  localparam count_t BAD32_LO = 28'hffffff0;
  localparam count_t BAD32_HI = 28'hffffff7;
  localparam count_t BAD16_LO = 28'h000fff0;
  localparam count_t BAD16_HI = 28'h000fff7;
  localparam count_t BAD12_LO = 28'h0000ff0;
  localparam count_t END12    = 28'h0000ff7;
  localparam count_t LIMIT12  = 28'd4080;

  // Table format codes; the unused code behaves as twelve-bit.
  typedef enum logic [1:0] {
    KIND_TWELVE     = 2'd0,
    KIND_SIXTEEN    = 2'd1,
    KIND_THIRTY_TWO = 2'd2
  } fat_kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FAT_KIND        = 3'd0,
    REG_RESERVED        = 3'd1,
    REG_FAT_SECTORS     = 3'd2,
    REG_FAT_COPIES      = 3'd3,
    REG_ROOT_ENTRIES    = 3'd4,
    REG_CLUSTER_SECTORS = 3'd5
  } cfg_reg_t;

  // One result transaction.
  typedef struct packed {
    logic       record_kind;
    sector_t    bad_sector;
    logic [7:0] map_slot;
    logic       map_full;
    count_t     used_total;
    count_t     bad_total;
    count_t     chain_ends;
    count_t     last_cluster;
    sector_t    last_data_sector;
    logic       run_end;
  } result_t;

  // Saturating increment of a 28-bit counter.
  function automatic count_t sat_inc(count_t v);
    count_t r;
    r = (v == SAT28) ? v : v + 28'd1;
    return r;
  endfunction

endpackage

// File: design/fat_bad_cluster_scanner.sv
// An accepted byte waits in the input register until the result queue has room.
// One byte per cycle while the queue has room; a final byte is held for a further
// step that emits the closing statistics. Both sector products come from
// registered operands. Reset (rst, synchronous) restores the configuration
// defaults, clears the scan state and empties the two-entry result queue.
// ----------------------------------------------------------------------------
// FAT bad cluster scanner
// Assembles FAT entries from a byte stream, classifies them, reports every
// bad cluster with its first sector and map slot, and closes with statistics.
// ----------------------------------------------------------------------------
`include "fat_bad_cluster_scanner_assert.svh"

module fat_bad_cluster_scanner #(
  parameter int unsigned BAD_MAP_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [7:0]        table_byte,
  input  logic              final_byte,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              record_kind,
  output fbcs_pkg::sector_t bad_sector,
  output logic [7:0]        map_slot,
  output logic              map_full,
  output fbcs_pkg::count_t  used_total,
  output fbcs_pkg::count_t  bad_total,
  output fbcs_pkg::count_t  chain_ends,
  output fbcs_pkg::count_t  last_cluster,
  output fbcs_pkg::sector_t last_data_sector,
  output logic              run_end
);
  import fbcs_pkg::*;

  localparam int unsigned FILL_W = $clog2(BAD_MAP_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(BAD_MAP_DEPTH);
  localparam logic [FILL_W-1:0] LAST_SLOT = FILL_W'(BAD_MAP_DEPTH - 1);

  // Configuration registers.
  logic [1:0]  fat_kind;
  logic [15:0] rsv_sectors;
  logic [31:0] fat_sectors;
  logic [7:0]  fat_copies;
  logic [15:0] root_entries;
  logic [7:0]  cluster_sectors;

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_kind         <= KIND_TWELVE;
      rsv_sectors      <= 16'd1;
      fat_sectors      <= 32'd1;
      fat_copies       <= 8'd2;
      root_entries     <= 16'd224;
      cluster_sectors  <= 8'd1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FAT_KIND:        fat_kind         <= cfg_data[1:0];
        REG_RESERVED:        rsv_sectors      <= cfg_data[15:0];
        REG_FAT_SECTORS:     fat_sectors      <= cfg_data;
        REG_FAT_COPIES:      fat_copies       <= cfg_data[7:0];
        REG_ROOT_ENTRIES:    root_entries     <= cfg_data[15:0];
        REG_CLUSTER_SECTORS: cluster_sectors  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // First data sector, registered from the configuration.
  logic [39:0] fat_area;
  logic [16:0] root_round;
  sector_t     root_sectors;
  sector_t     data_start;

  assign fat_area     = 40'(fat_sectors) * 40'(fat_copies);
  assign root_round   = {1'b0, root_entries} + 17'd15;
  assign root_sectors = (fat_kind == KIND_THIRTY_TWO) ? '0 : 32'(root_round[16:4]);

  always_ff @(posedge clk) begin
    data_start <= 32'(rsv_sectors) + fat_area[31:0] + root_sectors;
  end

  // Input register.
  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_final;
  logic       accept;
  logic       consume;
  logic       go;

  assign byte_stall = in_vld && !consume;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (consume) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte  <= table_byte;
      in_final <= final_byte;
    end
  end

  // Scan state.
  logic [23:0]       gather, gather_next;
  logic [1:0]        phase, phase_next;
  count_t            entry_number, entry_number_next;
  count_t            used_count, used_count_next;
  count_t            bad_tally, bad_tally_next;
  count_t            end_count, end_count_next;
  count_t            last_used_cluster, last_used_cluster_next;
  logic [FILL_W-1:0] map_fill, map_fill_next;
  logic              pend_close, pend_close_next;

  // Entry assembly from the gathered bytes.
  count_t entry;
  logic   take;

  always_comb begin
    gather_next = gather;
    phase_next  = phase;
    entry       = '0;
    take        = 1'b0;
    if (phase == 2'd0) begin
      gather_next = {16'h0, in_byte};
      phase_next  = 2'd1;
    end else if (fat_kind == KIND_SIXTEEN) begin
      entry      = {12'h0, in_byte, gather[7:0]};
      take       = 1'b1;
      phase_next = 2'd0;
    end else if (fat_kind == KIND_THIRTY_TWO) begin
      if (phase != 2'd3) begin
        gather_next = gather | (24'(in_byte) << {phase, 3'b000});
        phase_next  = phase + 2'd1;
      end else begin
        entry      = {in_byte[3:0], gather};
        take       = 1'b1;
        phase_next = 2'd0;
      end
    end else if (phase == 2'd1) begin
      gather_next = {8'h0, in_byte, gather[7:0]};
      entry       = {16'h0, in_byte[3:0], gather[7:0]};
      take        = 1'b1;
      phase_next  = 2'd2;
    end else begin
      entry      = {16'h0, in_byte, gather[15:12]};
      take       = 1'b1;
      phase_next = 2'd0;
    end
  end

  // Classification of the assembled entry.
  logic twelve;
  logic counted;
  logic is_bad;
  logic is_end;

  assign twelve  = (fat_kind != KIND_SIXTEEN) && (fat_kind != KIND_THIRTY_TWO);
  assign counted = take && (entry_number >= 28'd2) && (entry_number != SAT28) &&
                   !(twelve && (entry_number >= LIMIT12));

  always_comb begin
    case (fat_kind)
      KIND_THIRTY_TWO: begin
        is_bad = (entry >= BAD32_LO) && (entry <= BAD32_HI);
        is_end = entry > BAD32_HI;
      end
      KIND_SIXTEEN: begin
        is_bad = (entry >= BAD16_LO) && (entry <= BAD16_HI);
        is_end = entry > BAD16_HI;
      end
      default: begin
        is_end = entry > END12;
        is_bad = !is_end && (entry > BAD12_LO);
      end
    endcase
  end

  // Sector arithmetic on registered operands.
  count_t      bad_index;
  count_t      last_index;
  logic [35:0] bad_prod;
  logic [35:0] last_prod;
  sector_t     bad_sector_val;
  sector_t     last_sector_val;

  assign bad_index       = entry_number - 28'd2;
  assign last_index      = last_used_cluster - 28'd1;
  assign bad_prod        = 36'(bad_index) * 36'(cluster_sectors);
  assign last_prod       = 36'(last_index) * 36'(cluster_sectors);
  assign bad_sector_val  = data_start + bad_prod[31:0];
  assign last_sector_val = data_start + last_prod[31:0] - 32'd1;

  // Bad map slot selection.
  logic              map_room;
  logic [FILL_W-1:0] slot;

  assign map_room = map_fill < FILL_MAX;
  assign slot     = map_room ? map_fill : LAST_SLOT;

  // Result queue control.
  logic [1:0] res_cnt;
  logic       room;
  logic       push;
  logic       pop;
  result_t    rec;
  result_t    slot0;
  result_t    slot1;

  assign room    = res_cnt != 2'd2;
  assign go      = in_vld && room;
  assign consume = go && (pend_close || !in_final);

  // State update and record build for one step.
  always_comb begin
    entry_number_next      = entry_number;
    used_count_next        = used_count;
    bad_tally_next         = bad_tally;
    end_count_next         = end_count;
    last_used_cluster_next = last_used_cluster;
    map_fill_next          = map_fill;
    pend_close_next        = pend_close;
    push                   = 1'b0;
    rec                    = '0;
    rec.used_total         = used_count;
    rec.bad_total          = bad_tally;
    rec.chain_ends         = end_count;
    rec.last_cluster       = last_used_cluster;
    rec.last_data_sector   = last_sector_val;
    if (go && pend_close) begin
      // Closing statistics, then back to the start of a table.
      push                   = 1'b1;
      rec.record_kind        = 1'b1;
      rec.run_end            = 1'b1;
      entry_number_next      = '0;
      used_count_next        = '0;
      bad_tally_next         = '0;
      end_count_next         = '0;
      last_used_cluster_next = 28'd2;
      map_fill_next          = '0;
      pend_close_next        = 1'b0;
    end else if (go) begin
      if (take) begin
        entry_number_next = sat_inc(entry_number);
      end
      if (counted && !is_bad) begin
        if (entry != '0) begin
          used_count_next        = sat_inc(used_count);
          last_used_cluster_next = entry_number;
        end
        if (is_end) begin
          end_count_next = sat_inc(end_count);
        end
      end else if (counted) begin
        push           = 1'b1;
        bad_tally_next = sat_inc(bad_tally);
        map_fill_next  = slot + 1'b1;
        rec.bad_sector = bad_sector_val;
        rec.map_slot   = 8'(slot);
        rec.map_full   = !map_room;
        rec.bad_total  = bad_tally_next;
        rec.run_end    = !in_final;
      end
      pend_close_next = in_final;
    end
  end

  // Byte phase and gather follow only processed bytes; a close restarts them.
  always_ff @(posedge clk) begin
    if (rst) begin
      gather            <= '0;
      phase             <= 2'd0;
      entry_number      <= '0;
      used_count        <= '0;
      bad_tally         <= '0;
      end_count         <= '0;
      last_used_cluster <= 28'd2;
      map_fill          <= '0;
      pend_close        <= 1'b0;
    end else begin
      if (go && pend_close) begin
        gather <= '0;
        phase  <= 2'd0;
      end else if (go) begin
        gather <= gather_next;
        phase  <= phase_next;
      end
      entry_number      <= entry_number_next;
      used_count        <= used_count_next;
      bad_tally         <= bad_tally_next;
      end_count         <= end_count_next;
      last_used_cluster <= last_used_cluster_next;
      map_fill          <= map_fill_next;
      pend_close        <= pend_close_next;
    end
  end

  // Two-entry result queue: slot0 drives the ports, slot1 absorbs a stall.
  assign result_valid = res_cnt != 2'd0;
  assign pop          = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else begin
      res_cnt <= res_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((res_cnt == 2'd0) || ((res_cnt == 2'd1) && pop))) begin
      slot0 <= rec;
    end else if (push) begin
      slot1 <= rec;
    end else if (pop && (res_cnt == 2'd2)) begin
      slot0 <= slot1;
    end
  end

  assign record_kind      = slot0.record_kind;
  assign bad_sector       = slot0.bad_sector;
  assign map_slot         = slot0.map_slot;
  assign map_full         = slot0.map_full;
  assign used_total       = slot0.used_total;
  assign bad_total        = slot0.bad_total;
  assign chain_ends       = slot0.chain_ends;
  assign last_cluster     = slot0.last_cluster;
  assign last_data_sector = slot0.last_data_sector;
  assign run_end          = slot0.run_end;

  // Checks on the queue, the map fill and the closing sequence.
  `FBCS_ASSERT_ALWAYS(a_queue_bound, res_cnt != 2'd3)
  `FBCS_ASSERT_ALWAYS(a_fill_bound, map_fill <= FILL_MAX)
  `FBCS_ASSERT_IMPLY(a_pend_holds_item, pend_close, in_vld && in_final)
  `FBCS_ASSERT_NEXT(a_close_clears, go && pend_close, !pend_close && (entry_number == '0))
  `FBCS_ASSERT_IMPLY(a_close_ends_run, result_valid && slot0.record_kind, slot0.run_end && (slot0.bad_sector == '0))

endmodule

// File: tb/fat_bad_cluster_scanner_tb.sv
// ----------------------------------------------------------------------------
// FAT bad cluster scanner testbench
// Streams FAT tables of all three entry formats into the scanner under a
// range of volume geometries. An internal scanner model predicts every bad
// cluster record and closing statistics record, and each result transaction
// is checked field by field. Both sides insert random gaps, and at one point
// the result side holds off long enough to back the byte stream up.
// ----------------------------------------------------------------------------
module fat_bad_cluster_scanner_tb;
  import fbcs_pkg::*;

  localparam count_t     CNT_CEIL       = 28'hfffffff;
  localparam count_t     TWELVE_LIMIT   = 28'd4080;
  localparam int         MAP_DEPTH      = 256;
  localparam logic [1:0] KIND_SPARE     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         HOLD_CYCLES    = 400;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } byte_item_t;

  // DUT connections; the inputs are driven to known values from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = REG_FAT_KIND;
  logic [31:0] cfg_data = 32'd0;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  table_byte = 8'd0;
  logic        final_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        record_kind;
  sector_t     bad_sector;
  logic [7:0]  map_slot;
  logic        map_full;
  count_t      used_total;
  count_t      bad_total;
  count_t      chain_ends;
  count_t      last_cluster;
  sector_t     last_data_sector;
  logic        run_end;

  // Scanner model: configuration copy and scan state.
  logic [1:0]  cfg_kind = KIND_TWELVE;
  logic [15:0] cfg_rsv = 16'd1;
  logic [31:0] cfg_fsec = 32'd1;
  logic [7:0]  cfg_copies = 8'd2;
  logic [15:0] cfg_roots = 16'd224;
  logic [7:0]  cfg_csec = 8'd1;
  logic [23:0] partial_word = 24'd0;
  logic [1:0]  byte_pos = 2'd0;
  count_t      next_entry = 28'd0;
  count_t      used_seen = 28'd0;
  count_t      bad_seen = 28'd0;
  count_t      ends_seen = 28'd0;
  count_t      top_used = 28'd2;
  int unsigned slots_taken = 0;

  result_t     expected_records[$];
  byte_item_t  byte_queue[$];
  logic [31:0] entry_list[$];
  byte_item_t  next_item;
  result_t     want;
  result_t     got;
  int          queued_bytes = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          cyc = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  logic        held = 1'b0;

  fat_bad_cluster_scanner dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .table_byte(table_byte), .final_byte(final_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .record_kind(record_kind), .bad_sector(bad_sector), .map_slot(map_slot),
    .map_full(map_full), .used_total(used_total), .bad_total(bad_total),
    .chain_ends(chain_ends), .last_cluster(last_cluster),
    .last_data_sector(last_data_sector), .run_end(run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic count_t bump(count_t v);
    return (v == CNT_CEIL) ? v : v + 28'd1;
  endfunction

  // First data sector of the volume, wrapping at 32 bits.
  function sector_t data_origin();
    sector_t ds;
    ds = {16'd0, cfg_rsv} + cfg_fsec * {24'd0, cfg_copies};
    if (cfg_kind != KIND_THIRTY_TWO) begin
      ds = ds + (({16'd0, cfg_roots} + 32'd15) >> 4);
    end
    return ds;
  endfunction

  // Running statistics shared by both record kinds.
  function result_t stats_record();
    result_t r;
    r = '0;
    r.used_total = used_seen;
    r.bad_total = bad_seen;
    r.chain_ends = ends_seen;
    r.last_cluster = top_used;
    r.last_data_sector = data_origin() + ({4'd0, top_used} - 32'd1) * {24'd0, cfg_csec}
                         - 32'd1;
    return r;
  endfunction

  // Classify one assembled entry; a bad one yields a record.
  task grade_entry(input count_t e, input logic fin);
    count_t      n;
    logic        twelve;
    logic        bad;
    logic        chain;
    logic        full;
    int unsigned slot;
    result_t     r;
    n = next_entry;
    twelve = (cfg_kind != KIND_SIXTEEN) && (cfg_kind != KIND_THIRTY_TWO);
    next_entry = bump(next_entry);
    if (!(n < 2 || n == CNT_CEIL || (twelve && n >= TWELVE_LIMIT))) begin
      if (cfg_kind == KIND_THIRTY_TWO) begin
        bad = (e >= 28'hffffff0) && (e <= 28'hffffff7);
        chain = e > 28'hffffff7;
      end else if (cfg_kind == KIND_SIXTEEN) begin
        bad = (e >= 28'hfff0) && (e <= 28'hfff7);
        chain = e > 28'hfff7;
      end else begin
        chain = e > 28'hff7;
        bad = !chain && (e > 28'hff0);
      end
      if (!bad) begin
        if (e != 0) begin
          used_seen = bump(used_seen);
          top_used = n;
        end
        if (chain) begin
          ends_seen = bump(ends_seen);
        end
      end else begin
        // Once the map is full, the last slot is overwritten again.
        slot = (slots_taken < MAP_DEPTH) ? slots_taken : MAP_DEPTH - 1;
        full = slots_taken >= MAP_DEPTH;
        slots_taken = slot + 1;
        bad_seen = bump(bad_seen);
        r = stats_record();
        r.record_kind = 1'b0;
        r.bad_sector = data_origin() + ({4'd0, n} - 32'd2) * {24'd0, cfg_csec};
        r.map_slot = slot[7:0];
        r.map_full = full;
        r.run_end = !fin;
        expected_records.push_back(r);
      end
    end
  endtask

  // Advance the model by one accepted table byte.
  task scan_byte(input logic [7:0] b, input logic fin);
    logic [1:0] ph;
    result_t    r;
    ph = byte_pos;
    if (ph == 2'd0) begin
      partial_word = {16'd0, b};
      byte_pos = 2'd1;
    end else if (cfg_kind == KIND_SIXTEEN) begin
      grade_entry({12'd0, b, partial_word[7:0]}, fin);
      byte_pos = 2'd0;
    end else if (cfg_kind == KIND_THIRTY_TWO) begin
      if (ph < 2'd3) begin
        partial_word = partial_word | ({16'd0, b} << (8 * ph));
        byte_pos = ph + 2'd1;
      end else begin
        grade_entry({b[3:0], partial_word}, fin);
        byte_pos = 2'd0;
      end
    end else if (ph == 2'd1) begin
      partial_word = {8'd0, b, partial_word[7:0]};
      grade_entry({16'd0, b[3:0], partial_word[7:0]}, fin);
      byte_pos = 2'd2;
    end else begin
      grade_entry({16'd0, b, partial_word[15:12]}, fin);
      byte_pos = 2'd0;
    end
    // The final byte closes the table and clears the scan.
    if (fin) begin
      r = stats_record();
      r.record_kind = 1'b1;
      r.run_end = 1'b1;
      expected_records.push_back(r);
      partial_word = 24'd0;
      byte_pos = 2'd0;
      next_entry = 28'd0;
      used_seen = 28'd0;
      bad_seen = 28'd0;
      ends_seen = 28'd0;
      top_used = 28'd2;
      slots_taken = 0;
    end
  endtask

  // ------------------------------------------------------------- stimulus

  function logic take_break();
    return !(cyc >= 350 && cyc < 650) && ($urandom_range(0, 99) < 14);
  endfunction

  function logic [7:0] raw_byte();
    return ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
  endfunction

  function logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = lo;
      1: v = hi;
      default: v = $urandom_range(hi, lo);
    endcase
    return v;
  endfunction

  // An entry of the given format; the roll picks free, bad, end of chain,
  // the value just below the bad range, or an ordinary link.
  function logic [31:0] random_entry(logic [1:0] kind, int roll);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] top;
    logic [31:0] e;
    case (kind)
      KIND_SIXTEEN: begin
        lo = 32'hfff0; hi = 32'hfff7; top = 32'hffff;
      end
      KIND_THIRTY_TWO: begin
        lo = 32'h0ffffff0; hi = 32'h0ffffff7; top = 32'h0fffffff;
      end
      default: begin
        lo = 32'hff1; hi = 32'hff7; top = 32'hfff;
      end
    endcase
    if (roll < 30) e = 32'd0;
    else if (roll < 50) e = $urandom_range(hi, lo);
    else if (roll < 62) e = $urandom_range(top, hi + 1);
    else if (roll < 68) e = lo - 1;
    else e = $urandom_range(lo - 2, 1);
    if (kind == KIND_THIRTY_TWO) begin
      e[31:28] = 4'($urandom);
    end
    return e;
  endfunction

  // Pack entry_list into table bytes, add loose trailing bytes, queue them.
  task push_entries(input logic [1:0] kind, input int spare, input logic closing);
    logic [7:0]  bytes[$];
    logic [31:0] e0;
    logic [31:0] e1;
    int          i;
    bytes.delete();
    if (kind == KIND_SIXTEEN) begin
      foreach (entry_list[j]) begin
        bytes.push_back(entry_list[j][7:0]);
        bytes.push_back(entry_list[j][15:8]);
      end
    end else if (kind == KIND_THIRTY_TWO) begin
      foreach (entry_list[j]) begin
        bytes.push_back(entry_list[j][7:0]);
        bytes.push_back(entry_list[j][15:8]);
        bytes.push_back(entry_list[j][23:16]);
        bytes.push_back(entry_list[j][31:24]);
      end
    end else begin
      for (i = 0; i < entry_list.size(); i += 2) begin
        e0 = entry_list[i];
        e1 = (i + 1 < entry_list.size()) ? entry_list[i + 1] : 32'd0;
        bytes.push_back(e0[7:0]);
        bytes.push_back({e1[3:0], e0[11:8]});
        bytes.push_back(e1[11:4]);
      end
    end
    repeat (spare) bytes.push_back(raw_byte());
    if (bytes.size() == 0) bytes.push_back(raw_byte());
    foreach (bytes[j]) begin
      byte_queue.push_back('{value: bytes[j], last: closing && (j == bytes.size() - 1)});
    end
    queued_bytes += bytes.size();
    entry_list.delete();
  endtask

  task write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task apply_settings(input logic [1:0] kind, input logic [15:0] rsv,
                      input logic [31:0] fsec, input logic [7:0] copies,
                      input logic [15:0] roots, input logic [7:0] csec);
    write_reg(REG_FAT_KIND, {30'd0, kind});
    write_reg(REG_RESERVED, {16'd0, rsv});
    write_reg(REG_FAT_SECTORS, fsec);
    write_reg(REG_FAT_COPIES, {24'd0, copies});
    write_reg(REG_ROOT_ENTRIES, {16'd0, roots});
    write_reg(REG_CLUSTER_SECTORS, {24'd0, csec});
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_kind = kind;
    cfg_rsv = rsv;
    cfg_fsec = fsec;
    cfg_copies = copies;
    cfg_roots = roots;
    cfg_csec = csec;
  endtask

  // Wait until every byte is taken and every record has come back, then let
  // the pipeline drain of bytes that produced nothing.
  task settle();
    while (byte_queue.size() != 0 || byte_valid || expected_records.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int per;
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Twelve-bit boundaries under the reset geometry; the loose byte at the
    // end is a partial entry that must be dropped.
    entry_list = '{32'hff7, 32'hff1, 32'hff0, 32'hff1, 32'hff7, 32'hff8, 32'hfff, 32'h000};
    push_entries(KIND_TWELVE, 1, 1'b1);

    // Thirty-two-bit words with junk in the top nibble, largest geometry.
    settle();
    apply_settings(KIND_THIRTY_TWO, 16'hffff, 32'hffffffff, 8'hff, 16'hffff, 8'hff);
    entry_list = '{32'hfffffff7, 32'h00000000, 32'hfffffff0, 32'h0ffffff8};
    push_entries(KIND_THIRTY_TWO, 0, 1'b1);

    // Format changes part-way through a table, starting from the spare code
    // and the smallest geometry.
    settle();
    apply_settings(KIND_SPARE, 16'd0, 32'd1, 8'd1, 16'd0, 8'd1);
    push_entries(cfg_kind, 16, 1'b0);
    repeat (5) begin
      settle();
      apply_settings(2'($urandom_range(0, 3)), cfg_rsv, cfg_fsec, cfg_copies, cfg_roots,
                     cfg_csec);
      push_entries(cfg_kind, $urandom_range(3, 15), 1'b0);
    end
    push_entries(cfg_kind, 4, 1'b1);

    // A twelve-bit table made mostly of bad entries: it overflows the bad
    // map, so the later records keep landing in its last slot.
    settle();
    apply_settings(KIND_TWELVE, 16'd32, 32'd9, 8'd2, 16'd512, 8'd4);
    for (k = 0; k < 280; k++) begin
      if (k % 40 == 7) begin
        entry_list.push_back(random_entry(KIND_TWELVE, $urandom_range(0, 99)));
      end else begin
        entry_list.push_back(random_entry(KIND_TWELVE, 40));
      end
    end
    push_entries(KIND_TWELVE, 0, 1'b1);

    // Short random tables under random geometries.
    while (queued_bytes < 640) begin
      settle();
      apply_settings(2'($urandom_range(0, 3)), 16'(pick(0, 65535)), pick(1, 32'hffffffff),
                     8'(pick(1, 255)), 16'(pick(0, 65535)), 8'(pick(1, 255)));
      per = (cfg_kind == KIND_THIRTY_TWO) ? 4 : ((cfg_kind == KIND_SIXTEEN) ? 2 : 3);
      repeat ($urandom_range(2, 16)) begin
        entry_list.push_back(random_entry(cfg_kind, $urandom_range(0, 99)));
      end
      push_entries(cfg_kind, $urandom_range(0, per - 1), 1'b1);
    end

    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Byte driver: holds a stalled transaction, otherwise offers the next byte
  // unless it takes a random gap.
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        scan_byte(table_byte, final_byte);
        bytes_taken++;
      end
      if (!byte_valid || !byte_stall) begin
        if (byte_queue.size() != 0 && !take_break()) begin
          next_item = byte_queue.pop_front();
          byte_valid <= 1'b1;
          table_byte <= next_item.value;
          final_byte <= next_item.last;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- checks

  task field_diff(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    mismatches++;
  endtask

  // Result monitor: checks each accepted transaction against the oldest
  // prediction and drives the stall, including one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got = {record_kind, bad_sector, map_slot, map_full, used_total, bad_total,
               chain_ends, last_cluster, last_data_sector, run_end};
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d sector %0h",
                   $time, record_kind, bad_sector);
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          if (got.record_kind !== want.record_kind)
            field_diff("record_kind", want.record_kind, got.record_kind);
          if (got.bad_sector !== want.bad_sector)
            field_diff("bad_sector", want.bad_sector, got.bad_sector);
          if (got.map_slot !== want.map_slot)
            field_diff("map_slot", want.map_slot, got.map_slot);
          if (got.map_full !== want.map_full)
            field_diff("map_full", want.map_full, got.map_full);
          if (got.used_total !== want.used_total)
            field_diff("used_total", want.used_total, got.used_total);
          if (got.bad_total !== want.bad_total)
            field_diff("bad_total", want.bad_total, got.bad_total);
          if (got.chain_ends !== want.chain_ends)
            field_diff("chain_ends", want.chain_ends, got.chain_ends);
          if (got.last_cluster !== want.last_cluster)
            field_diff("last_cluster", want.last_cluster, got.last_cluster);
          if (got.last_data_sector !== want.last_data_sector)
            field_diff("last_data_sector", want.last_data_sector, got.last_data_sector);
          if (got.run_end !== want.run_end)
            field_diff("run_end", want.run_end, got.run_end);
        end
      end
      if (!held && bytes_taken >= 300) begin
        held <= 1'b1;
        hold_left <= HOLD_CYCLES;
        result_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= take_break();
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst) begin
      if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// File: filelist.f
+incdir+design
design/fbcs_pkg.sv
design/fat_bad_cluster_scanner.sv
tb/fat_bad_cluster_scanner_tb.sv
